@@ hw/rtl/bwg_pkg.sv @@
// Shared types and constants for the B-spline weight and gradient block.
// Standalone package; used by every module under hw/rtl except bwg_queue.
package bwg_pkg;

  // Port widths
  localparam int unsigned POS_W    = 17;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned GRAD_W   = 23;

  // Spline values and derivative magnitudes never exceed 1.0 in Q.16
  localparam int unsigned N_W    = 17;
  localparam int unsigned PROD_W = 2 * N_W - 1;

  // Q.16 constants
  localparam int unsigned HALF_Q16    = 32768;
  localparam int unsigned THREEQ_Q16  = 49152;
  localparam int unsigned ONEHALF_Q16 = 98304;
  localparam int unsigned TWO_Q16     = 131072;

  // Gradient saturation limits
  localparam int unsigned GRAD_POS_MAX = (1 << (GRAD_W - 1)) - 1;
  localparam int unsigned GRAD_NEG_MAG = (1 << (GRAD_W - 1));

  // Reciprocal shift for division by constants
  localparam int unsigned RECIP_SH = 32;

  localparam int unsigned GRID_DIMS_DEF = 32;

  // Pipeline depths and queue sizes
  localparam int unsigned FE_LAT   = 9;
  localparam int unsigned BE_LAT   = 3;
  localparam int unsigned MQ_DEPTH = 16;
  localparam int unsigned OQ_DEPTH = 8;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [N_W-1:0] dmag;
    logic           dneg;
  } axis_t;

  // Request handed from the front pipeline to the back pipeline
  typedef struct packed {
    axis_t [2:0] ax;
    logic        too_far;
  } mid_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]      weight;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     too_far;
  } res_t;

endpackage

@@ hw/rtl/bspline_weight_and_gradient.sv @@
// Top level of the quadratic B-spline weight and gradient block.
// Depends on bwg_pkg, bwg_queue, bwg_front and bwg_back.
//
// Usage
//   Input side is a queue write port: present pos_x/y/z and cell_index with
//   push high; the request is taken at a rising edge where full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on weight, grad_x/y/z and too_far; pop high takes it at the edge.
// Throughput
//   One request per clock, sustained, while the result side keeps popping.
// Path
//   A taken request passes through 9 stages of coordinate decode and spline
//   evaluation, the middle queue, 3 stages of products and scaling, and the
//   result queue before its result shows on the result ports.
// Stalls
//   The front pipeline reserves a middle-queue slot for each request it
//   takes, and the back pipeline reserves a result-queue slot for each one it
//   starts, so neither pipeline ever stalls mid-flight. When pop stays low the
//   result queue fills, the back stops drawing, and then full rises.
// Reset
//   rst (synchronous) drops everything in flight and empties both queues.
module bspline_weight_and_gradient #(
  parameter int unsigned GRID_DIMS = bwg_pkg::GRID_DIMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [bwg_pkg::POS_W-1:0]         pos_x,
  input  logic [bwg_pkg::POS_W-1:0]         pos_y,
  input  logic [bwg_pkg::POS_W-1:0]         pos_z,
  input  logic [bwg_pkg::CELL_W-1:0]        cell_index,
  output logic                              empty,
  input  logic                              pop,
  output logic [bwg_pkg::WEIGHT_W-1:0]      weight,
  output logic signed [bwg_pkg::GRAD_W-1:0] grad_x,
  output logic signed [bwg_pkg::GRAD_W-1:0] grad_y,
  output logic signed [bwg_pkg::GRAD_W-1:0] grad_z,
  output logic                              too_far
);
  import bwg_pkg::*;

  logic accept;
  logic fe_valid;
  mid_t fe_item;
  logic mq_empty;
  logic [$bits(mid_t)-1:0] mq_rd_data;
  logic oq_full;
  logic be_start;
  logic be_valid;
  res_t be_item;
  logic [$bits(res_t)-1:0] oq_rd_data;
  res_t res;

  // Take a request only when a middle-queue slot is free for it
  assign accept   = push && !full;
  // Start the back part only when a result slot is free
  assign be_start = !mq_empty && !oq_full;

  bwg_front #(.GRID_DIMS(GRID_DIMS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .cell_index (cell_index),
    .out_valid  (fe_valid),
    .out_item   (fe_item)
  );

  bwg_queue #(.W($bits(mid_t)), .DEPTH(MQ_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .reserve (accept),
    .full    (full),
    .wr_en   (fe_valid),
    .wr_data (fe_item),
    .rd_en   (be_start),
    .rd_data (mq_rd_data),
    .empty   (mq_empty)
  );

  bwg_back #(.GRID_DIMS(GRID_DIMS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (be_start),
    .in_item   (mid_t'(mq_rd_data)),
    .out_valid (be_valid),
    .out_item  (be_item)
  );

  bwg_queue #(.W($bits(res_t)), .DEPTH(OQ_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .reserve (be_start),
    .full    (oq_full),
    .wr_en   (be_valid),
    .wr_data (be_item),
    .rd_en   (pop),
    .rd_data (oq_rd_data),
    .empty   (empty)
  );

  // Hold the oldest result on the ports until it is popped
  assign res     = res_t'(oq_rd_data);
  assign weight  = res.weight;
  assign grad_x  = res.grad_x;
  assign grad_y  = res.grad_y;
  assign grad_z  = res.grad_z;
  assign too_far = res.too_far;

endmodule

@@ hw/rtl/bwg_queue.sv @@
// Small register queue with slot reservation, so that a fixed-latency
// pipeline in front of it never overruns it. Depends on nothing.
module bwg_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         reserve,
  output logic         full,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] occ;
  logic [CW-1:0] slots;
  logic          rd_fire;

  assign rd_fire = rd_en && !empty;
  assign empty   = (occ == '0);
  assign full    = (slots == CW'(DEPTH));
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
      slots  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      occ   <= occ + CW'(wr_en) - CW'(rd_fire);
      slots <= slots + CW'(reserve) - CW'(rd_fire);
    end
  end

endmodule

@@ hw/rtl/bwg_front.sv @@
// Front pipeline: splits the cell index into coordinates and evaluates the
// spline and its derivative per axis. Depends on bwg_pkg.
module bwg_front #(
  parameter int unsigned GRID_DIMS = bwg_pkg::GRID_DIMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [bwg_pkg::POS_W-1:0]  pos_x,
  input  logic [bwg_pkg::POS_W-1:0]  pos_y,
  input  logic [bwg_pkg::POS_W-1:0]  pos_z,
  input  logic [bwg_pkg::CELL_W-1:0] cell_index,
  output logic                       out_valid,
  output bwg_pkg::mid_t              out_item
);
  import bwg_pkg::*;

  localparam int unsigned DIM    = GRID_DIMS + 3;
  localparam int unsigned DIM2   = DIM * DIM;
  localparam int unsigned CZ_MAX = ((1 << CELL_W) - 1) / DIM2;
  localparam int unsigned CZ_W   = (CZ_MAX < 1) ? 1 : $clog2(CZ_MAX + 1);
  localparam int unsigned CXY_W  = $clog2(DIM);
  localparam int unsigned CW     = (CZ_W > CXY_W) ? CZ_W : CXY_W;
  localparam int unsigned RZ_W   = $clog2(2 * DIM2);
  localparam int unsigned REMZ_W = $clog2(DIM2);
  localparam int unsigned RY_W   = $clog2(2 * DIM);
  localparam longint unsigned MZ = (64'd1 << RECIP_SH) / DIM2;
  localparam longint unsigned MY = (64'd1 << RECIP_SH) / DIM;
  localparam int unsigned PZ_W   = RECIP_SH + CZ_W;
  localparam int unsigned PY_W   = RECIP_SH + CXY_W;
  localparam int unsigned PG_W   = POS_W + $clog2(GRID_DIMS + 1);
  localparam int unsigned CS_W   = CW + 16;
  localparam int unsigned DW     = ((PG_W > CS_W) ? PG_W : CS_W) + 1;

  localparam logic [1:0] RGN_INNER = 2'd0;
  localparam logic [1:0] RGN_OUTER = 2'd1;
  localparam logic [1:0] RGN_ZERO  = 2'd2;

  logic [FE_LAT-1:0] vld;

  // Stage 1..6: coordinate decode
  logic [POS_W-1:0]  pos1 [3];
  logic [POS_W-1:0]  pos2 [3];
  logic [POS_W-1:0]  pos3 [3];
  logic [POS_W-1:0]  pos4 [3];
  logic [POS_W-1:0]  pos5 [3];
  logic [POS_W-1:0]  pos6 [3];
  logic [CELL_W-1:0] c1;
  logic [PZ_W-1:0]   pz1;
  logic [63:0]       pz_full;
  logic [CZ_W-1:0]   qz2;
  logic [RZ_W-1:0]   rz2;
  logic [31:0]       rz_full;
  logic [CZ_W-1:0]   cz_c;
  logic [REMZ_W-1:0] remz_c;
  logic [CZ_W-1:0]   cz3;
  logic [REMZ_W-1:0] remz3;
  logic [CZ_W-1:0]   cz4;
  logic [REMZ_W-1:0] remz4;
  logic [PY_W-1:0]   py4;
  logic [63:0]       py_full;
  logic [CZ_W-1:0]   cz5;
  logic [CXY_W-1:0]  qy5;
  logic [RY_W-1:0]   ry5;
  logic [31:0]       ry_full;
  logic [CXY_W-1:0]  cy_c;
  logic [CXY_W-1:0]  cx_c;
  logic [CW-1:0]     coord6 [3];

  // Stage 7..9: spline evaluation
  logic [PG_W-1:0]      posp [3];
  logic [CS_W-1:0]      negp [3];
  logic signed [DW-1:0] d_c  [3];
  logic signed [DW-1:0] d7   [3];
  logic [DW-1:0]        a_c  [3];
  logic [N_W-1:0]       t_c  [3];
  logic [1:0]           rgn_c [3];
  logic [N_W-1:0]       s_c  [3];
  logic [N_W-1:0]       dm_c [3];
  logic [2:0]           dneg_c;
  logic [2:0]           far_c;
  logic [N_W-1:0]       s8   [3];
  logic [1:0]           rgn8 [3];
  logic [N_W-1:0]       dm8  [3];
  logic [2:0]           dneg8;
  logic [2:0]           far8;
  logic [2*N_W-1:0]     sq_c [3];
  logic [N_W-1:0]       n_c  [3];

  assign out_valid = vld[FE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FE_LAT-2:0], in_valid};
    end
  end

  // Division by constants: multiply by reciprocal, then one correction step
  assign pz_full = 64'(cell_index) * MZ;
  assign rz_full = 32'(c1) - 32'(pz1[RECIP_SH +: CZ_W]) * 32'(DIM2);
  assign py_full = 64'(remz3) * MY;
  assign ry_full = 32'(remz4) - 32'(py4[RECIP_SH +: CXY_W]) * 32'(DIM);

  always_comb begin
    if (rz2 >= RZ_W'(DIM2)) begin
      cz_c   = qz2 + 1'b1;
      remz_c = REMZ_W'(rz2 - RZ_W'(DIM2));
    end else begin
      cz_c   = qz2;
      remz_c = REMZ_W'(rz2);
    end
    if (ry5 >= RY_W'(DIM)) begin
      cy_c = qy5 + 1'b1;
      cx_c = CXY_W'(ry5 - RY_W'(DIM));
    end else begin
      cy_c = qy5;
      cx_c = CXY_W'(ry5);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      posp[i] = PG_W'(pos6[i]) * PG_W'(GRID_DIMS) + PG_W'(HALF_Q16);
      negp[i] = {coord6[i], 16'b0};
      d_c[i]  = $signed(DW'(posp[i])) - $signed(DW'(negp[i]));

      a_c[i]    = d7[i][DW-1] ? DW'(-d7[i]) : DW'(d7[i]);
      t_c[i]    = N_W'(DW'(ONEHALF_Q16) - a_c[i]);
      far_c[i]  = a_c[i] > DW'(TWO_Q16);
      if (a_c[i] < DW'(HALF_Q16)) begin
        rgn_c[i] = RGN_INNER;
        s_c[i]   = N_W'(a_c[i]);
        dm_c[i]  = N_W'({a_c[i], 1'b0});
      end else if (a_c[i] < DW'(ONEHALF_Q16)) begin
        rgn_c[i] = RGN_OUTER;
        s_c[i]   = t_c[i];
        dm_c[i]  = t_c[i];
      end else begin
        rgn_c[i] = RGN_ZERO;
        s_c[i]   = '0;
        dm_c[i]  = '0;
      end
      // derivative points against d; zero where the derivative is zero
      dneg_c[i] = !d7[i][DW-1] && (d7[i] != '0) && (rgn_c[i] != RGN_ZERO);

      sq_c[i] = (2*N_W)'(s8[i]) * (2*N_W)'(s8[i]);
      unique case (rgn8[i])
        RGN_INNER: n_c[i] = N_W'(THREEQ_Q16) - N_W'(sq_c[i] >> 16);
        RGN_OUTER: n_c[i] = N_W'(sq_c[i] >> 17);
        default:   n_c[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos1   <= '{pos_x, pos_y, pos_z};
    c1     <= cell_index;
    pz1    <= pz_full[PZ_W-1:0];

    pos2   <= pos1;
    qz2    <= pz1[RECIP_SH +: CZ_W];
    rz2    <= rz_full[RZ_W-1:0];

    pos3   <= pos2;
    cz3    <= cz_c;
    remz3  <= remz_c;

    pos4   <= pos3;
    cz4    <= cz3;
    remz4  <= remz3;
    py4    <= py_full[PY_W-1:0];

    pos5   <= pos4;
    cz5    <= cz4;
    qy5    <= py4[RECIP_SH +: CXY_W];
    ry5    <= ry_full[RY_W-1:0];

    pos6      <= pos5;
    coord6[0] <= CW'(cx_c);
    coord6[1] <= CW'(cy_c);
    coord6[2] <= CW'(cz5);

    d7 <= d_c;

    s8    <= s_c;
    rgn8  <= rgn_c;
    dm8   <= dm_c;
    dneg8 <= dneg_c;
    far8  <= far_c;

    for (int i = 0; i < 3; i++) begin
      out_item.ax[i].n    <= n_c[i];
      out_item.ax[i].dmag <= dm8[i];
      out_item.ax[i].dneg <= dneg8[i];
    end
    out_item.too_far <= |far8;
  end

endmodule

@@ hw/rtl/bwg_back.sv @@
// Back pipeline: forms the weight and gradient products, scales and
// saturates the gradient. Depends on bwg_pkg.
module bwg_back #(
  parameter int unsigned GRID_DIMS = bwg_pkg::GRID_DIMS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bwg_pkg::mid_t in_item,
  output logic          out_valid,
  output bwg_pkg::res_t out_item
);
  import bwg_pkg::*;

  localparam int unsigned GM_W = N_W + $clog2(GRID_DIMS + 1);
  localparam int unsigned MW   = (GM_W > GRAD_W) ? GM_W : GRAD_W;

  logic [BE_LAT-1:0] vld;

  logic [PROD_W-1:0] pxy1;
  logic [PROD_W-1:0] pdxy1;
  logic [PROD_W-1:0] pxdy1;
  logic [N_W-1:0]    nz1;
  logic [N_W-1:0]    dz1;
  logic [2:0]        dneg1;
  logic              far1;

  logic [PROD_W-1:0] w2;
  logic [PROD_W-1:0] gx2;
  logic [PROD_W-1:0] gy2;
  logic [PROD_W-1:0] gz2;
  logic [2:0]        dneg2;
  logic              far2;

  function automatic logic signed [GRAD_W-1:0] grad_scale(input logic [N_W-1:0] mag,
                                                          input logic neg);
    logic [MW-1:0] m;
    m = MW'(mag) * MW'(GRID_DIMS);
    if (neg) begin
      if (m > MW'(GRAD_NEG_MAG)) begin
        m = MW'(GRAD_NEG_MAG);
      end
      return GRAD_W'(MW'(0) - m);
    end
    if (m > MW'(GRAD_POS_MAX)) begin
      m = MW'(GRAD_POS_MAX);
    end
    return GRAD_W'(m);
  endfunction

  assign out_valid = vld[BE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pxy1  <= PROD_W'(in_item.ax[0].n) * PROD_W'(in_item.ax[1].n);
    pdxy1 <= PROD_W'(in_item.ax[0].dmag) * PROD_W'(in_item.ax[1].n);
    pxdy1 <= PROD_W'(in_item.ax[0].n) * PROD_W'(in_item.ax[1].dmag);
    nz1   <= in_item.ax[2].n;
    dz1   <= in_item.ax[2].dmag;
    dneg1 <= {in_item.ax[2].dneg, in_item.ax[1].dneg, in_item.ax[0].dneg};
    far1  <= in_item.too_far;

    w2    <= PROD_W'(pxy1[PROD_W-1:16]) * PROD_W'(nz1);
    gx2   <= PROD_W'(pdxy1[PROD_W-1:16]) * PROD_W'(nz1);
    gy2   <= PROD_W'(pxdy1[PROD_W-1:16]) * PROD_W'(nz1);
    gz2   <= PROD_W'(pxy1[PROD_W-1:16]) * PROD_W'(dz1);
    dneg2 <= dneg1;
    far2  <= far1;

    out_item.weight  <= WEIGHT_W'(w2[PROD_W-1:16]);
    out_item.grad_x  <= grad_scale(N_W'(gx2[PROD_W-1:16]), dneg2[0]);
    out_item.grad_y  <= grad_scale(N_W'(gy2[PROD_W-1:16]), dneg2[1]);
    out_item.grad_z  <= grad_scale(N_W'(gz2[PROD_W-1:16]), dneg2[2]);
    out_item.too_far <= far2;
  end

endmodule

@@ hw/rtl/bwg_checker.sv @@
// Port-level checks for the B-spline weight and gradient block, bound to
// the top level. Depends on bwg_pkg.
module bwg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [bwg_pkg::WEIGHT_W-1:0]      weight,
  input logic signed [bwg_pkg::GRAD_W-1:0] grad_x,
  input logic signed [bwg_pkg::GRAD_W-1:0] grad_y,
  input logic signed [bwg_pkg::GRAD_W-1:0] grad_z,
  input logic                              too_far
);
  import bwg_pkg::*;

  // Drop everything on reset: no result and room for requests
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not cleared by reset");

  // Beyond two cells the spline is zero on that axis
  a_far_is_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && too_far |-> weight == '0 && grad_x == '0 && grad_y == '0 && grad_z == '0)
    else $error("nonzero result for a distant cell");

  // Weight is a product of three values no larger than one
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> weight <= WEIGHT_W'(1 << 16))
    else $error("weight above one");

  // Hold an unpopped result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable({weight, grad_x, grad_y, grad_z, too_far}))
    else $error("waiting result changed");

endmodule

bind bspline_weight_and_gradient bwg_checker u_bwg_checker (.*);
